FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of this project.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/sbdt_pkg.sv
// Shared types and constants of the signed binary to decimal text converter.
// Depends on nothing; used by the shift-and-add-3 unit and the top level.
`default_nettype none
package sbdt_pkg;

   // Sequencer states of the converter.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   localparam int unsigned CHAR_W = 7;
   localparam int unsigned DIGIT_W = 4;

   // ASCII '-' and the upper three bits shared by the codes '0' to '9'.
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
   localparam logic [CHAR_W-DIGIT_W-1:0] CHAR_DIGIT_HI = 3'b011;

   // Largest value a decimal digit may hold.
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   // Threshold and correction of one shift-and-add-3 step.
   localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

endpackage
`default_nettype wire

FILE: rtl/core/sbdt_dabble.sv
// One shift-and-add-3 step over a packed BCD register, shifting in one binary bit.
// Depends on sbdt_pkg for the digit width and the correction constants.
`default_nettype none
module sbdt_dabble #(
   parameter int unsigned DIGITS = 20
) (
   input  wire logic [DIGITS*sbdt_pkg::DIGIT_W-1:0] bcd_i,
   input  wire logic                                bit_i,
   output      logic [DIGITS*sbdt_pkg::DIGIT_W-1:0] bcd_o
);

   localparam int unsigned BCD_W = DIGITS * sbdt_pkg::DIGIT_W;

   logic [BCD_W-1:0] adj;

   // Every digit of five or more is corrected before the doubling shift.
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_i[d*sbdt_pkg::DIGIT_W +: sbdt_pkg::DIGIT_W] >= sbdt_pkg::DABBLE_LIMIT) begin
            adj[d*sbdt_pkg::DIGIT_W +: sbdt_pkg::DIGIT_W] =
               bcd_i[d*sbdt_pkg::DIGIT_W +: sbdt_pkg::DIGIT_W] + sbdt_pkg::DABBLE_ADD;
         end else begin
            adj[d*sbdt_pkg::DIGIT_W +: sbdt_pkg::DIGIT_W] =
               bcd_i[d*sbdt_pkg::DIGIT_W +: sbdt_pkg::DIGIT_W];
         end
      end
   end

   assign bcd_o = {adj[BCD_W-2:0], bit_i};

endmodule
`default_nettype wire

FILE: rtl/core/signed_binary_to_decimal_text_top.sv
// Top level of the signed binary to decimal text converter.
// Depends on sbdt_pkg, sbdt_dabble and assert_macros.svh.
//
//   Channel | Direction | Payload                 | Per transaction
//   req_    | in        | value (64b, signed)     | one integer
//   rsp_    | out       | char_code (7b), last    | one ASCII character
//
// A transaction is taken and negated while idle, then the shared dabble unit takes in
// the magnitude bit by bit, MSB first, then leading zeros are dropped one digit at a
// time, then the characters are sent one by one, a minus sign first if negative.
// Reset is synchronous and clears the sequencer and the response valid only.
// A stalled response holds its character and the sequencer waits. req_ready is high
// while idle, which is reentered once the last character is loaded.
`default_nettype none
`include "assert_macros.svh"
module signed_binary_to_decimal_text_top #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [63:0]                  req_value,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [sbdt_pkg::CHAR_W-1:0]  rsp_char_code,
   output      logic                         rsp_last
);

   // Decimal digits needed for any magnitude below 2^VALUE_BITS.
   localparam int unsigned NUM_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int unsigned BCD_W = NUM_DIGITS * sbdt_pkg::DIGIT_W;
   localparam int unsigned CNT_W = $clog2(VALUE_BITS);
   localparam int unsigned DCNT_W = $clog2(NUM_DIGITS + 1);

   sbdt_pkg::state_type state_ff, state_in;

   logic [VALUE_BITS-1:0]        mag_ff, mag_in;
   logic [BCD_W-1:0]             bcd_ff, bcd_in;
   logic [CNT_W-1:0]             bitcnt_ff, bitcnt_in;
   logic [DCNT_W-1:0]            dcnt_ff, dcnt_in;
   logic                         neg_ff, neg_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sbdt_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [VALUE_BITS-1:0]        req_bits;
   logic [BCD_W-1:0]             step_bcd;
   logic [sbdt_pkg::DIGIT_W-1:0] top_digit;
   logic                         req_take;
   logic                         out_free;

   // Views used by the checks at the end of the module.
   logic                         rsp_is_minus;
   logic                         rsp_is_digit;
   logic                         trim_exit;
   logic                         in_text;

   assign req_bits  = req_value[VALUE_BITS-1:0];
   assign top_digit = bcd_ff[BCD_W-1 -: sbdt_pkg::DIGIT_W];
   assign req_ready = (state_ff == sbdt_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;
   // The response register can take a character when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   assign rsp_is_minus = (rsp_char_ff == sbdt_pkg::CHAR_MINUS);
   assign rsp_is_digit =
      (rsp_char_ff[sbdt_pkg::CHAR_W-1:sbdt_pkg::DIGIT_W] == sbdt_pkg::CHAR_DIGIT_HI) &&
      (rsp_char_ff[sbdt_pkg::DIGIT_W-1:0] <= sbdt_pkg::DIGIT_MAX);
   assign trim_exit = (state_ff == sbdt_pkg::ST_TRIM) && (state_in != sbdt_pkg::ST_TRIM);
   assign in_text   = (state_ff == sbdt_pkg::ST_DIGITS) || (state_ff == sbdt_pkg::ST_TRIM);

   // Shared shift-and-add-3 unit; the magnitude feeds it MSB first.
   sbdt_dabble #(
      .DIGITS (NUM_DIGITS)
   ) u_dabble (
      .bcd_i (bcd_ff),
      .bit_i (mag_ff[VALUE_BITS-1]),
      .bcd_o (step_bcd)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbdt_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = sbdt_pkg::ST_CONVERT;
            end
         end
         sbdt_pkg::ST_CONVERT: begin
            if (bitcnt_ff == '0) begin
               state_in = sbdt_pkg::ST_TRIM;
            end
         end
         sbdt_pkg::ST_TRIM: begin
            // Leading zeros are dropped, but at least one digit is always kept.
            if (!(top_digit == '0 && dcnt_ff > DCNT_W'(1))) begin
               state_in = neg_ff ? sbdt_pkg::ST_SIGN : sbdt_pkg::ST_DIGITS;
            end
         end
         sbdt_pkg::ST_SIGN: begin
            if (out_free) begin
               state_in = sbdt_pkg::ST_DIGITS;
            end
         end
         sbdt_pkg::ST_DIGITS: begin
            if (out_free && dcnt_ff == DCNT_W'(1)) begin
               state_in = sbdt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbdt_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and response register controls.
   always_comb begin
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      bitcnt_in    = bitcnt_ff;
      dcnt_in      = dcnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         sbdt_pkg::ST_IDLE: begin
            if (req_take) begin
               // The most negative value negates to itself, which read unsigned
               // is exactly its magnitude.
               neg_in    = req_bits[VALUE_BITS-1];
               mag_in    = req_bits[VALUE_BITS-1] ? (~req_bits + VALUE_BITS'(1)) : req_bits;
               bcd_in    = '0;
               bitcnt_in = CNT_W'(VALUE_BITS - 1);
               dcnt_in   = DCNT_W'(NUM_DIGITS);
            end
         end
         sbdt_pkg::ST_CONVERT: begin
            bcd_in    = step_bcd;
            mag_in    = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bitcnt_in = bitcnt_ff - CNT_W'(1);
         end
         sbdt_pkg::ST_TRIM: begin
            if (top_digit == '0 && dcnt_ff > DCNT_W'(1)) begin
               bcd_in  = {bcd_ff[BCD_W-sbdt_pkg::DIGIT_W-1:0], {sbdt_pkg::DIGIT_W{1'b0}}};
               dcnt_in = dcnt_ff - DCNT_W'(1);
            end
         end
         sbdt_pkg::ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = sbdt_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
            end
         end
         sbdt_pkg::ST_DIGITS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = {sbdt_pkg::CHAR_DIGIT_HI, top_digit};
               rsp_last_in  = (dcnt_ff == DCNT_W'(1));
               bcd_in  = {bcd_ff[BCD_W-sbdt_pkg::DIGIT_W-1:0], {sbdt_pkg::DIGIT_W{1'b0}}};
               dcnt_in = dcnt_ff - DCNT_W'(1);
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbdt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      bitcnt_ff   <= bitcnt_in;
      dcnt_ff     <= dcnt_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // An accepted request always starts the bit-serial conversion.
   `ASSERT_NEXT(a_take_starts, clock, reset, req_take, state_ff == sbdt_pkg::ST_CONVERT)
   // A minus sign is never the final character of a number.
   `ASSERT_IMPLY(a_sign_not_last, clock, reset, rsp_valid_ff && rsp_is_minus, !rsp_last_ff)
   // Every character sent is a minus sign or a decimal digit.
   `ASSERT_IMPLY(a_char_legal, clock, reset, rsp_valid_ff, rsp_is_minus || rsp_is_digit)
   // Output starts at a nonzero digit unless the number is a single digit.
   `ASSERT_IMPLY(a_no_lead_zero, clock, reset, trim_exit && dcnt_ff > DCNT_W'(1), top_digit != '0)
   // Digits are only sent while some remain.
   `ASSERT_IMPLY(a_digits_left, clock, reset, in_text, dcnt_ff != '0)

endmodule
`default_nettype wire
